// ----- hw/rtl/wgbl_pkg.sv -----
// Shared types and constants for the wrapped grid bilinear lookup block.
package wgbl_pkg;

    localparam int CELLS_PER_DEGREE_DEF = 1;

    // Stream word widths (fields packed from bit 0, padded to whole bytes).
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 24;

    // Field widths.
    localparam int LON_IDX_W = 9;
    localparam int LAT_IDX_W = 8;
    localparam int DEPTH_W   = 16;
    localparam int QLON_W    = 17;
    localparam int QLAT_W    = 16;
    localparam int WORD_W    = DEPTH_W + 1;

    // Fixed-point position constants, 1/256 degree.
    localparam int FRAC_W    = 8;
    localparam int FRAC_ONE  = 256;
    localparam int LON_SHIFT = 360 * 256;
    localparam int LAT_SHIFT = 90 * 256;
    localparam int LAT_SPAN  = 180 * 256;

    // Interpolation datapath widths.
    localparam int WEIGHT_W  = FRAC_W + 1;
    localparam int PART_W    = DEPTH_W + FRAC_W;
    localparam int ACC_W     = 32;

    // Item kinds on tuser.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD00,
        S_RD10,
        S_RD01,
        S_RD11,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_DONE
    } state_t;

endpackage

// ----- hw/rtl/wgbl_ram.sv -----
// Generic single-port synchronous RAM with registered read.
module wgbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wr_data,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wr_data;
        end
        rd_data_reg <= mem[addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/wrapped_grid_bilinear_lookup_core.sv -----
// Top level of the wrapped lat/lon grid with bilinear depth lookup.
//
// Usage:
//   Slave stream (s_*) carries write and query words; tuser selects the kind
//   (0 = write one grid cell, 1 = query a position). A write stores depth and
//   extended flag of one cell and produces no result; cells outside the grid
//   are dropped. A query returns one master word (m_*) with the truncated
//   bilinear depth and the OR of the four corner flags.
//   Longitude wraps at the east edge, latitude clamps at the poles.
// Query sequence:
//   A write is taken while idle and leaves the block idle. A query steps
//   through RD00, RD10, RD01, RD11, MUL0..MUL3 and DONE; no new word is taken
//   until it is back in idle. Its length is set by the single grid RAM port
//   (four corner reads) and the one shared 24x9 multiplier (six products per query).
// Reset:
//   aresetn (sync, active low) starts a clearing pass that writes zero to
//   every one of the 360*CPD*(180*CPD+1) cells (65160 at CPD=1), one per cycle.
//   s_tready stays low until it ends.
// Stall:
//   The result sits in an output register; s_tready returns while it waits.
//   A later query holds in its last step until the register frees up.
module wrapped_grid_bilinear_lookup_core #(
    parameter int CELLS_PER_DEGREE = wgbl_pkg::CELLS_PER_DEGREE_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // op
    input  logic [0:0]                       s_tuser,
    // cell_lon[8:0], cell_lat[16:9], cell_depth[32:17], cell_extended[33],
    // query_lon[50:34], query_lat[66:51], zero pad[71:67]
    input  logic [wgbl_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // depth[15:0], extended_nearby[16], zero pad[23:17]
    output logic [wgbl_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready
);

    // Grid geometry follows from the resolution.
    localparam int GRID_W     = 360 * CELLS_PER_DEGREE;
    localparam int GRID_H     = 180 * CELLS_PER_DEGREE + 1;
    localparam int GRID_CELLS = GRID_W * GRID_H;
    localparam int ADDR_W     = $clog2(GRID_CELLS);
    localparam int COL_W      = $clog2(GRID_W);
    localparam int ROW_W      = $clog2(GRID_H);
    localparam int LON_POS_W  = $clog2(wgbl_pkg::LON_SHIFT * CELLS_PER_DEGREE);
    localparam int LAT_POS_W  = $clog2(wgbl_pkg::LAT_SPAN * CELLS_PER_DEGREE + 1);

    localparam int FW = wgbl_pkg::FRAC_W;
    localparam int DW = wgbl_pkg::DEPTH_W;
    localparam int PW = wgbl_pkg::PART_W;
    localparam int AW = wgbl_pkg::ACC_W;
    localparam int WW = wgbl_pkg::WEIGHT_W;

    // Input word fields.
    logic [wgbl_pkg::LON_IDX_W-1:0] in_cell_lon;
    logic [wgbl_pkg::LAT_IDX_W-1:0] in_cell_lat;
    logic [DW-1:0]                  in_cell_depth;
    logic                           in_cell_extended;
    logic signed [wgbl_pkg::QLON_W-1:0] in_query_lon;
    logic signed [wgbl_pkg::QLAT_W-1:0] in_query_lat;

    assign in_cell_lon      = s_tdata[8:0];
    assign in_cell_lat      = s_tdata[16:9];
    assign in_cell_depth    = s_tdata[32:17];
    assign in_cell_extended = s_tdata[33];
    assign in_query_lon     = s_tdata[50:34];
    assign in_query_lat     = s_tdata[66:51];

    wgbl_pkg::state_t state_reg, state_next;

    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [COL_W-1:0]  col_reg, col_next, col1_reg, col1_next;
    logic [ROW_W-1:0]  row_reg, row_next, row1_reg, row1_next;
    logic [FW-1:0]     s_frac_reg, s_frac_next, t_frac_reg, t_frac_next;
    logic [DW-1:0]     d00_reg, d00_next, d10_reg, d10_next;
    logic [DW-1:0]     d01_reg, d01_next, d11_reg, d11_next;
    logic              flag_reg, flag_next;
    logic [PW-1:0]     a_reg, a_next, b_reg, b_next;
    logic [AW-1:0]     prod_reg, prod_next, acc_reg, acc_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [wgbl_pkg::OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // RAM port.
    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_addr;
    logic [wgbl_pkg::WORD_W-1:0] ram_wdata, ram_rdata;
    logic [DW-1:0]             rd_depth;
    logic                      rd_flag;

    assign rd_depth = ram_rdata[DW-1:0];
    assign rd_flag  = ram_rdata[DW];

    wgbl_ram #(
        .WIDTH(wgbl_pkg::WORD_W),
        .DEPTH(GRID_CELLS)
    ) u_grid_ram (
        .aclk   (aclk),
        .we     (ram_we),
        .addr   (ram_addr),
        .wr_data(ram_wdata),
        .rd_data(ram_rdata)
    );

    // Query front end: shift to 0..360 / 0..180 deg, scale, split index and fraction.
    logic signed [wgbl_pkg::QLON_W:0] lon_ext;
    logic [wgbl_pkg::QLON_W-1:0]      lon_u;
    logic signed [wgbl_pkg::QLAT_W:0] lat_sh;
    logic [wgbl_pkg::QLAT_W-1:0]      lat_u;
    logic [LON_POS_W-1:0]             lon_pos;
    logic [LAT_POS_W-1:0]             lat_pos;
    logic [COL_W-1:0]                 q_col;
    logic [ROW_W-1:0]                 q_row;
    logic [COL_W:0]                   q_col_inc;
    logic [ROW_W:0]                   q_row_inc;

    always_comb begin
        lon_ext = {in_query_lon[wgbl_pkg::QLON_W-1], in_query_lon};
        if (lon_ext < 0) begin
            lon_ext = lon_ext + (wgbl_pkg::QLON_W+1)'(wgbl_pkg::LON_SHIFT);
        end
        lon_u = lon_ext[wgbl_pkg::QLON_W-1:0];

        lat_sh = {in_query_lat[wgbl_pkg::QLAT_W-1], in_query_lat}
               + (wgbl_pkg::QLAT_W+1)'(wgbl_pkg::LAT_SHIFT);
        priority if (lat_sh < 0) begin
            lat_u = '0;
        end else if (lat_sh > (wgbl_pkg::QLAT_W+1)'(wgbl_pkg::LAT_SPAN)) begin
            lat_u = wgbl_pkg::QLAT_W'(wgbl_pkg::LAT_SPAN);
        end else begin
            lat_u = lat_sh[wgbl_pkg::QLAT_W-1:0];
        end

        lon_pos = LON_POS_W'(lon_u * CELLS_PER_DEGREE);
        lat_pos = LAT_POS_W'(lat_u * CELLS_PER_DEGREE);
        q_col   = lon_pos[FW +: COL_W];
        q_row   = lat_pos[FW +: ROW_W];

        // East neighbor wraps to column 0; north neighbor clamps to last row.
        q_col_inc = {1'b0, q_col} + 1'b1;
        q_row_inc = {1'b0, q_row} + 1'b1;
    end

    // Write address and range check.
    logic              wr_in_grid;
    logic [ADDR_W-1:0] wr_addr;

    assign wr_in_grid = (32'(in_cell_lon) < GRID_W) && (32'(in_cell_lat) < GRID_H);
    assign wr_addr    = ADDR_W'(32'(in_cell_lat) * GRID_W) + ADDR_W'(in_cell_lon);

    // Corner address for the current read step.
    logic [COL_W-1:0]  col_sel;
    logic [ROW_W-1:0]  row_sel;
    logic [ADDR_W-1:0] corner_addr;

    always_comb begin
        unique case (state_reg)
            wgbl_pkg::S_RD10: begin
                col_sel = col1_reg;
                row_sel = row_reg;
            end
            wgbl_pkg::S_RD01: begin
                col_sel = col_reg;
                row_sel = row1_reg;
            end
            wgbl_pkg::S_RD11: begin
                col_sel = col1_reg;
                row_sel = row1_reg;
            end
            default: begin
                col_sel = col_reg;
                row_sel = row_reg;
            end
        endcase
        corner_addr = ADDR_W'(32'(row_sel) * GRID_W) + ADDR_W'(col_sel);
    end

    // Shared multiplier.
    logic [PW-1:0]    mul_a;
    logic [WW-1:0]    mul_b;
    logic [PW+WW-1:0] mul_p;
    logic [WW-1:0]    ws_lo, ws_hi, wt_lo, wt_hi;

    assign ws_lo = WW'(wgbl_pkg::FRAC_ONE) - WW'(s_frac_reg);
    assign ws_hi = WW'(s_frac_reg);
    assign wt_lo = WW'(wgbl_pkg::FRAC_ONE) - WW'(t_frac_reg);
    assign wt_hi = WW'(t_frac_reg);
    assign mul_p = mul_a * mul_b;

    logic              s_fire, out_free;
    logic [AW-1:0]     acc_sum;

    assign s_tready = (state_reg == wgbl_pkg::S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign acc_sum  = acc_reg + prod_reg;

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        col_next      = col_reg;
        col1_next     = col1_reg;
        row_next      = row_reg;
        row1_next     = row1_reg;
        s_frac_next   = s_frac_reg;
        t_frac_next   = t_frac_reg;
        d00_next      = d00_reg;
        d10_next      = d10_reg;
        d01_next      = d01_reg;
        d11_next      = d11_reg;
        flag_next     = flag_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        ram_we        = 1'b0;
        ram_addr      = corner_addr;
        ram_wdata     = {in_cell_extended, in_cell_depth};
        mul_a         = PW'(d00_reg);
        mul_b         = ws_lo;

        unique case (state_reg)
            wgbl_pkg::S_CLEAR: begin
                ram_we       = 1'b1;
                ram_addr     = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (32'(clr_cnt_reg) == GRID_CELLS - 1) begin
                    state_next = wgbl_pkg::S_IDLE;
                end
            end
            wgbl_pkg::S_IDLE: begin
                ram_addr = wr_addr;
                if (s_fire) begin
                    if (s_tuser[0] == wgbl_pkg::OP_WRITE) begin
                        ram_we = wr_in_grid;
                    end else begin
                        col_next    = q_col;
                        col1_next   = (32'(q_col_inc) >= GRID_W) ? '0 : q_col_inc[COL_W-1:0];
                        row_next    = q_row;
                        row1_next   = (32'(q_row_inc) >= GRID_H) ? ROW_W'(GRID_H - 1)
                                                                 : q_row_inc[ROW_W-1:0];
                        s_frac_next = lon_pos[FW-1:0];
                        t_frac_next = lat_pos[FW-1:0];
                        state_next  = wgbl_pkg::S_RD00;
                    end
                end
            end
            wgbl_pkg::S_RD00: begin
                state_next = wgbl_pkg::S_RD10;
            end
            wgbl_pkg::S_RD10: begin
                d00_next   = rd_depth;
                flag_next  = rd_flag;
                state_next = wgbl_pkg::S_RD01;
            end
            wgbl_pkg::S_RD01: begin
                d10_next   = rd_depth;
                flag_next  = flag_reg | rd_flag;
                mul_a      = PW'(d00_reg);
                mul_b      = ws_lo;
                prod_next  = AW'(mul_p);
                state_next = wgbl_pkg::S_RD11;
            end
            wgbl_pkg::S_RD11: begin
                d01_next   = rd_depth;
                flag_next  = flag_reg | rd_flag;
                mul_a      = PW'(d10_reg);
                mul_b      = ws_hi;
                prod_next  = AW'(mul_p);
                a_next     = prod_reg[PW-1:0];
                state_next = wgbl_pkg::S_MUL0;
            end
            wgbl_pkg::S_MUL0: begin
                d11_next   = rd_depth;
                flag_next  = flag_reg | rd_flag;
                mul_a      = PW'(d01_reg);
                mul_b      = ws_lo;
                prod_next  = AW'(mul_p);
                a_next     = a_reg + prod_reg[PW-1:0];
                state_next = wgbl_pkg::S_MUL1;
            end
            wgbl_pkg::S_MUL1: begin
                mul_a      = PW'(d11_reg);
                mul_b      = ws_hi;
                prod_next  = AW'(mul_p);
                b_next     = prod_reg[PW-1:0];
                state_next = wgbl_pkg::S_MUL2;
            end
            wgbl_pkg::S_MUL2: begin
                // Lower row blend done; blend it in latitude while the upper row finishes.
                mul_a      = a_reg;
                mul_b      = wt_lo;
                prod_next  = AW'(mul_p);
                b_next     = b_reg + prod_reg[PW-1:0];
                state_next = wgbl_pkg::S_MUL3;
            end
            wgbl_pkg::S_MUL3: begin
                mul_a      = b_reg;
                mul_b      = wt_hi;
                prod_next  = AW'(mul_p);
                acc_next   = prod_reg;
                state_next = wgbl_pkg::S_DONE;
            end
            wgbl_pkg::S_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {(wgbl_pkg::OUT_TDATA_W-DW-1)'(0), flag_reg,
                                     acc_sum[AW-1 -: DW]};
                    state_next    = wgbl_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = wgbl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= wgbl_pkg::S_CLEAR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        col_reg     <= col_next;
        col1_reg    <= col1_next;
        row_reg     <= row_next;
        row1_reg    <= row1_next;
        s_frac_reg  <= s_frac_next;
        t_frac_reg  <= t_frac_next;
        d00_reg     <= d00_next;
        d10_reg     <= d10_next;
        d01_reg     <= d01_next;
        d11_reg     <= d11_next;
        flag_reg    <= flag_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- hw/rtl/wgbl_checker.sv -----
// Port-level assertions for the grid lookup core, bound to the top level.
module wgbl_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic [0:0]                       s_tuser,
    input logic [wgbl_pkg::IN_TDATA_W-1:0]  s_tdata,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [wgbl_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                             m_tvalid,
    input logic                             m_tready
);

    // Stalled result word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A query occupies the block on the following cycle.
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == wgbl_pkg::OP_QUERY) |=> !s_tready)
        else $error("input accepted right after a query");

    // A new result only appears out of the query sequence, never from idle.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while block was idle");

endmodule

bind wrapped_grid_bilinear_lookup_core wgbl_checker u_wgbl_checker (.*);
